// ----- hw/rtl/apm_pkg.sv -----
// ============================================================================
// apm_pkg
// Shared widths, register indexes and sequencer states of the approximate
// pattern matcher.
// ============================================================================
`default_nettype none

package apm_pkg;

   // Default sizes of the matcher
   localparam int PATTERN_MAX_DEF  = 32;
   localparam int ERROR_LEVELS_DEF = 8;

   // Payload widths
   localparam int TEXT_W     = 8;
   localparam int START_W    = 33;
   localparam int EDIT_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int PLEN_W     = 6;
   localparam int MERR_W     = 3;
   localparam int PAT_REGS   = 4;
   localparam int PAT_BYTES  = PAT_REGS * CSR_DATA_W / TEXT_W;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAT_0_7   = 3'd0,
      CSR_PAT_8_15  = 3'd1,
      CSR_PAT_16_23 = 3'd2,
      CSR_PAT_24_31 = 3'd3,
      CSR_PAT_LEN   = 3'd4,
      CSR_MAX_ERR   = 3'd5
   } csr_idx_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_EMIT
   } seq_state_type;

endpackage : apm_pkg

`default_nettype wire

// ----- hw/rtl/apm_if.sv -----
// ============================================================================
// apm channel interfaces
// Valid/ready channels for text bytes, match results and register writes.
// ============================================================================
`default_nettype none

interface apm_req_if import apm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TEXT_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface : apm_req_if

interface apm_rsp_if import apm_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [START_W-1:0] match_start;
   logic [EDIT_W-1:0]         edit_count;
   logic                      last_match;

   modport source (output valid, output match_start, output edit_count,
                   output last_match, input ready);
   modport sink   (input valid, input match_start, input edit_count,
                   input last_match, output ready);
endinterface : apm_rsp_if

interface apm_csr_if import apm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : apm_csr_if

`default_nettype wire

// ----- hw/rtl/apm_ram.sv -----
// ============================================================================
// apm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module apm_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output      logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule : apm_ram

`default_nettype wire

// ----- hw/rtl/apm_csr.sv -----
// ============================================================================
// apm_csr
// Pattern registers and the per-byte active-low match mask.
// ============================================================================
`default_nettype none

module apm_csr import apm_pkg::*; #(
   parameter int  PATTERN_MAX = PATTERN_MAX_DEF,
   localparam int TOP_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   apm_csr_if.sink                     csr_chan,
   input  wire logic [TEXT_W-1:0]      text_byte,
   output      logic [PATTERN_MAX-1:0] byte_mask,
   output      logic [TOP_W-1:0]       top_bit,
   output      logic [MERR_W-1:0]      max_errors
);
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CLW   = (LEN_W > PLEN_W) ? LEN_W : PLEN_W;

   logic [CSR_DATA_W-1:0] pat_ff [PAT_REGS];
   logic [PLEN_W-1:0]     plen_ff;
   logic [MERR_W-1:0]     merr_ff;
   logic [CLW-1:0]        len_c;
   logic [CLW-1:0]        len_ext;

   assign csr_chan.ready = 1'b1;

   // Take register beats; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < PAT_REGS; r++) begin
            pat_ff[r] <= '0;
         end
         plen_ff <= PLEN_W'(1);
         merr_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_PAT_0_7:   pat_ff[0] <= csr_chan.data;
            CSR_PAT_8_15:  pat_ff[1] <= csr_chan.data;
            CSR_PAT_16_23: pat_ff[2] <= csr_chan.data;
            CSR_PAT_24_31: pat_ff[3] <= csr_chan.data;
            CSR_PAT_LEN:   plen_ff   <= csr_chan.data[PLEN_W-1:0];
            CSR_MAX_ERR:   merr_ff   <= csr_chan.data[MERR_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the length into 1..PATTERN_MAX
   always_comb begin
      len_ext = CLW'(plen_ff);
      if (len_ext == '0) begin
         len_c = CLW'(1);
      end else if (len_ext > CLW'(PATTERN_MAX)) begin
         len_c = CLW'(PATTERN_MAX);
      end else begin
         len_c = len_ext;
      end
   end

   assign top_bit    = TOP_W'(len_c - CLW'(1));
   assign max_errors = merr_ff;

   // Compare each pattern byte against the text byte; zero marks a hit
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_mask
      logic [TEXT_W-1:0] pbyte;
      if (i < PAT_BYTES) begin : g_reg
         assign pbyte = pat_ff[i / 8][(i % 8) * 8 +: 8];
      end else begin : g_zero
         assign pbyte = '0;
      end
      assign byte_mask[i] = !((pbyte == text_byte) && (len_c > CLW'(i)));
   end
endmodule : apm_csr

`default_nettype wire

// ----- hw/rtl/approximate_pattern_matcher_unit.sv -----
// ============================================================================
// approximate_pattern_matcher_unit
// Bitap (Wu-Manber) approximate search over a byte stream with up to
// max_errors insertions, deletions and substitutions.
// ============================================================================
//
//  channel  | dir | payload                                  | beat
//  ---------+-----+------------------------------------------+---------------
//  req_chan | in  | text_byte[7:0]                           | one text byte
//  rsp_chan | out | match_start[32:0] s, edit_count, last    | one match
//  csr_chan | in  | index[2:0], data[63:0]                   | register write
//
//  A byte is taken in ST_IDLE; the level vectors live in a one-port-read,
//  one-port-write RAM and are updated one level per cycle, then the hits
//  are sent one beat per cycle while rsp_chan is ready.
//  Reset clears the level valid bits, so every level reads as all ones.
//  A stalled rsp_chan holds the current beat; no byte is taken until the last
//  match beat of the previous byte has left. csr_chan is always ready.
// ============================================================================
`default_nettype none

module approximate_pattern_matcher_unit import apm_pkg::*; #(
   parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
   parameter int ERROR_LEVELS = ERROR_LEVELS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   apm_req_if.sink   req_chan,
   apm_rsp_if.source rsp_chan,
   apm_csr_if.sink   csr_chan
);
   localparam int TOP_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LVL_W = (ERROR_LEVELS > 1) ? $clog2(ERROR_LEVELS) : 1;
   localparam int CMP_W = (LVL_W > MERR_W) ? LVL_W : MERR_W;

   seq_state_type             state_ff, state_in;
   logic [PATTERN_MAX-1:0]    mask_ff, mask_in;
   logic [PATTERN_MAX-1:0]    prev_old_ff, prev_old_in;
   logic [PATTERN_MAX-1:0]    prev_new_ff, prev_new_in;
   logic [ERROR_LEVELS-1:0]   hits_ff, hits_in;
   logic [ERROR_LEVELS-1:0]   valid_ff, valid_in;
   logic [LVL_W-1:0]          lvl_ff, lvl_in;
   logic [31:0]               index_ff, index_in;
   logic signed [START_W-1:0] start_ff, start_in;

   logic [PATTERN_MAX-1:0]    byte_mask;
   logic [TOP_W-1:0]          top_bit;
   logic [MERR_W-1:0]         max_errors;

   logic [PATTERN_MAX-1:0]    rd_data;
   logic [PATTERN_MAX-1:0]    old_vec;
   logic [PATTERN_MAX-1:0]    new_vec;
   logic [LVL_W-1:0]          rd_addr;
   logic                      wr_en;

   logic [LVL_W-1:0]          low_idx;
   logic [ERROR_LEVELS-1:0]   low_bit;
   logic                      req_beat;

   // Pattern registers and byte mask
   apm_csr #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_chan   (csr_chan),
      .text_byte  (req_chan.text_byte),
      .byte_mask  (byte_mask),
      .top_bit    (top_bit),
      .max_errors (max_errors)
   );

   // Level vector store
   apm_ram #(
      .WIDTH (PATTERN_MAX),
      .DEPTH (ERROR_LEVELS)
   ) u_level_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lvl_ff),
      .wr_data (new_vec),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A level never written since reset reads as all ones
   assign old_vec = valid_ff[lvl_ff] ? rd_data : '1;

   // Bitap recurrence for the level in flight
   always_comb begin
      new_vec = (old_vec << 1) | mask_ff;
      if (lvl_ff != '0) begin
         new_vec = new_vec & prev_old_ff & (prev_new_ff << 1) & (prev_old_ff << 1);
      end
   end

   // Lowest pending hit
   always_comb begin
      low_idx = '0;
      for (int k = ERROR_LEVELS - 1; k >= 0; k--) begin
         if (hits_ff[k]) begin
            low_idx = LVL_W'(k);
         end
      end
      low_bit = '0;
      low_bit[low_idx] = 1'b1;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign req_beat             = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid       = (state_ff == ST_EMIT);
   assign rsp_chan.match_start = start_ff;
   assign rsp_chan.edit_count  = EDIT_W'(low_idx);
   assign rsp_chan.last_match  = ((hits_ff & ~low_bit) == '0);

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in    = state_ff;
      mask_in     = mask_ff;
      prev_old_in = prev_old_ff;
      prev_new_in = prev_new_ff;
      hits_in     = hits_ff;
      valid_in    = valid_ff;
      lvl_in      = lvl_ff;
      index_in    = index_ff;
      start_in    = start_ff;
      rd_addr     = '0;
      wr_en       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Take a text beat and fetch level zero
            if (req_beat) begin
               mask_in  = byte_mask;
               start_in = $signed({1'b0, index_ff} - START_W'(top_bit));
               index_in = index_ff + 32'd1;
               lvl_in   = '0;
               hits_in  = '0;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Write back this level, fetch the next one
            rd_addr          = lvl_ff + LVL_W'(1);
            wr_en            = 1'b1;
            valid_in[lvl_ff] = 1'b1;
            prev_old_in      = old_vec;
            prev_new_in      = new_vec;
            hits_in[lvl_ff]  = !new_vec[top_bit] &&
                               (CMP_W'(lvl_ff) <= CMP_W'(max_errors));
            lvl_in           = lvl_ff + LVL_W'(1);
            if (lvl_ff == LVL_W'(ERROR_LEVELS - 1)) begin
               state_in = (hits_in != '0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            // Drop the sent hit; leave after the last beat
            if (rsp_chan.ready) begin
               hits_in = hits_ff & ~low_bit;
               if (rsp_chan.last_match) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         index_ff <= '0;
         hits_ff  <= '0;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         index_ff <= index_in;
         hits_ff  <= hits_in;
         lvl_ff   <= lvl_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      prev_old_ff <= prev_old_in;
      prev_new_ff <= prev_new_in;
      start_ff    <= start_in;
   end
endmodule : approximate_pattern_matcher_unit

`default_nettype wire

// ----- tb/tb.sv -----
// ============================================================================
// tb
// Self-checking bench for the approximate pattern matcher. Text bytes are
// streamed against a set of patterns, lengths and edit limits while both
// channels idle at random. A bitap predictor keeps its own level vectors and
// byte index and queues the matches each accepted byte must produce. A checker
// compares every result beat, field by field, against the oldest queued match.
// ============================================================================
`default_nettype none

module tb;
   import apm_pkg::*;

   localparam int PMAX          = PATTERN_MAX_DEF;
   localparam int LEVELS        = ERROR_LEVELS_DEF;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 24;
   localparam int WATCHDOG_MAX  = 2000;

   // Indexes past the register list; writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum int {EDIT_SUB, EDIT_DEL, EDIT_INS} edit_kind_type;

   typedef struct packed {
      logic signed [START_W-1:0] start;
      logic [EDIT_W-1:0]         edits;
      logic                      last;
   } match_rec_type;

   logic clock;
   logic reset;

   apm_req_if req_bus ();
   apm_rsp_if rsp_bus ();
   apm_csr_if csr_bus ();

   approximate_pattern_matcher_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Predictor state: registers, level vectors and byte index
   logic [CSR_DATA_W-1:0] pat_word [PAT_REGS];
   logic [PLEN_W-1:0]     pat_len_reg;
   logic [MERR_W-1:0]     max_err_reg;
   logic [PMAX-1:0]       level_vec [LEVELS];
   logic [31:0]           text_pos;

   match_rec_type pending_matches [$];
   int         fail_count;
   int         bytes_sent;
   int         tx_calm_left;
   int         hold_ticket;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic int active_len();
      if (pat_len_reg == 0)
         return 1;
      if (pat_len_reg > PMAX)
         return PMAX;
      return int'(pat_len_reg);
   endfunction

   function automatic logic [7:0] pat_byte(input int i);
      return pat_word[i / 8][8 * (i % 8) +: 8];
   endfunction

   // Advance every level by one text byte and queue the matches it ends
   task automatic bitap_advance(input logic [TEXT_W-1:0] c);
      logic [PMAX-1:0]    mask;
      logic [PMAX-1:0]    nxt [LEVELS];
      logic [START_W-1:0] start;
      match_rec_type      rec;
      int                 len, i, k, top_hit;
      len = active_len();
      mask = '1;
      for (i = 0; i < len; i++)
         if (pat_byte(i) == c)
            mask[i] = 1'b0;
      nxt[0] = (level_vec[0] << 1) | mask;
      for (k = 1; k < LEVELS; k++)
         nxt[k] = ((level_vec[k] << 1) | mask) & level_vec[k-1] & (nxt[k-1] << 1)
                  & (level_vec[k-1] << 1);
      start = {1'b0, text_pos} - START_W'(len - 1);
      // find the highest reported hit so it can carry the last flag
      top_hit = -1;
      for (k = 0; k <= int'(max_err_reg) && k < LEVELS; k++)
         if (!nxt[k][len-1])
            top_hit = k;
      for (k = 0; k <= top_hit; k++) begin
         if (!nxt[k][len-1]) begin
            rec.start = start;
            rec.edits = EDIT_W'(k);
            rec.last  = (k == top_hit);
            pending_matches.insert(pending_matches.size(), rec);
         end
      end
      for (k = 0; k < LEVELS; k++)
         level_vec[k] = nxt[k];
      text_pos = text_pos + 32'd1;
   endtask

   // ------------------------------------------------------------------------
   // Idle lengths: mostly short, now and then long
   // ------------------------------------------------------------------------
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(1, 3);
      if (r < 95)
         return $urandom_range(4, 10);
      return $urandom_range(15, 40);
   endfunction

   function automatic int tx_gap();
      int r;
      if (tx_calm_left > 0) begin
         tx_calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         tx_calm_left = $urandom_range(15, 40);
         return 0;
      end
      if (r < 60)
         return 0;
      return idle_len();
   endfunction

   // ------------------------------------------------------------------------
   // Channel drivers
   // ------------------------------------------------------------------------
   // Offer one text byte; valid stays high for a back-to-back beat
   task automatic send_byte(input logic [TEXT_W-1:0] b);
      int gap;
      gap = tx_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.text_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      bitap_advance(b);
      bytes_sent++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_PAT_0_7:   pat_word[0] = val;
         CSR_PAT_8_15:  pat_word[1] = val;
         CSR_PAT_16_23: pat_word[2] = val;
         CSR_PAT_24_31: pat_word[3] = val;
         CSR_PAT_LEN:   pat_len_reg = val[PLEN_W-1:0];
         CSR_MAX_ERR:   max_err_reg = val[MERR_W-1:0];
         default: ;
      endcase
   endtask

   // Drop valid, wait out every queued match, then let the level pass finish
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_matches.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_config(input logic [CSR_DATA_W-1:0] words [PAT_REGS],
                              input logic [PLEN_W-1:0] plen,
                              input logic [MERR_W-1:0] merr);
      settle();
      csr_write(CSR_PAT_0_7,   words[0]);
      csr_write(CSR_PAT_8_15,  words[1]);
      csr_write(CSR_PAT_16_23, words[2]);
      csr_write(CSR_PAT_24_31, words[3]);
      csr_write(CSR_PAT_LEN,   CSR_DATA_W'(plen));
      csr_write(CSR_MAX_ERR,   CSR_DATA_W'(merr));
      csr_bus.valid <= 1'b0;
   endtask

   // Send the current pattern with a few random edits spread over it
   task automatic send_near_copy(input int edits);
      edit_kind_type kind;
      int         len, i, left;
      len = active_len();
      left = edits;
      for (i = 0; i < len; i++) begin
         if (left > 0 && $urandom_range(0, len - 1) < edits) begin
            left--;
            kind = edit_kind_type'($urandom_range(0, 2));
            case (kind)
               EDIT_SUB: send_byte(8'($urandom));
               EDIT_DEL: ;
               default: begin
                  send_byte(8'($urandom));
                  send_byte(pat_byte(i));
               end
            endcase
         end else begin
            send_byte(pat_byte(i));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Reset pattern is one zero byte with no errors allowed
   task automatic test_reset_defaults();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
   endtask

   // Hits early in the byte stream start before byte zero
   task automatic test_negative_start();
      logic [CSR_DATA_W-1:0] words [PAT_REGS];
      words = '{64'h4847_4645_4443_4241, 64'h0, 64'h0, 64'h0};
      load_config(words, 6'd8, 3'd7);
      send_byte(8'h41);
      send_byte(8'h42);
      send_byte(8'h43);
      send_byte(8'h44);
      send_byte(8'h45);
   endtask

   // Zero length acts as one; spare indexes are ignored
   task automatic test_length_edges();
      logic [CSR_DATA_W-1:0] words [PAT_REGS];
      words = '{64'h0000_0000_0000_00FF, 64'h0, 64'h0, 64'h0};
      load_config(words, 6'd0, 3'd0);
      csr_write(CSR_SPARE_LO, '1);
      csr_write(CSR_SPARE_HI, '1);
      csr_bus.valid <= 1'b0;
      send_byte(8'hFF);
      send_byte(8'h7F);
      send_byte(8'hFF);
   endtask

   // Byte values at both ends, including the all-ones byte in the pattern
   task automatic test_text_extremes();
      logic [CSR_DATA_W-1:0] words [PAT_REGS];
      words = '{64'h0000_0000_0000_FF00, 64'h0, 64'h0, 64'h0};
      load_config(words, 6'd2, 3'd1);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // Hold the result side off while bytes keep coming, so the input stalls
   task automatic test_backpressure();
      logic [CSR_DATA_W-1:0] words [PAT_REGS];
      words = '{64'h0000_0000_0000_005A, 64'h0, 64'h0, 64'h0};
      load_config(words, 6'd1, 3'd7);
      tx_calm_left = 100;
      hold_ticket <= hold_ticket + 1;
      send_byte(8'h5A);
      send_byte(8'h5A);
      send_byte(8'h00);
      send_byte(8'h5A);
      send_byte(8'hA5);
      send_byte(8'h5A);
      tx_calm_left = 0;
   endtask

   // Phases of random patterns; text is mostly near copies of the pattern
   task automatic test_random_search();
      logic [CSR_DATA_W-1:0] words [PAT_REGS];
      logic [PLEN_W-1:0]     plen;
      logic [MERR_W-1:0]     merr;
      int                    phase, w, budget, r, cap;
      for (phase = 0; phase < 8; phase++) begin
         // odd phases flip every pattern bit of the phase before
         for (w = 0; w < PAT_REGS; w++)
            words[w] = (phase % 2 == 1) ? ~words[w] : {$urandom, $urandom};
         case (phase)
            0: begin plen = 6'd1;  merr = 3'd0; end
            1: begin plen = 6'd32; merr = 3'd7; end
            2: begin plen = 6'd5;  merr = 3'd3; end
            3: begin plen = 6'd63; merr = 3'd7; end
            4: begin plen = PLEN_W'($urandom_range(2, 8)); merr = MERR_W'($urandom); end
            5: begin plen = PLEN_W'($urandom_range(2, 12)); merr = 3'd7; end
            6: begin plen = PLEN_W'($urandom_range(2, 8)); merr = MERR_W'($urandom); end
            default: begin plen = 6'd3; merr = 3'd0; end
         endcase
         load_config(words, plen, merr);
         budget = bytes_sent + ((active_len() > 16) ? 40 : 18);
         cap = (max_err_reg < 3) ? int'(max_err_reg) + 1 : 3;
         while (bytes_sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 60)
               send_near_copy($urandom_range(0, cap));
            else if (r < 85)
               send_byte(pat_byte($urandom_range(0, active_len() - 1)));
            else
               send_byte(8'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random ready, with a long hold on request
   // ------------------------------------------------------------------------
   initial begin
      int stall_left, run_left, seen_ticket, r;
      stall_left = 0;
      run_left = 0;
      seen_ticket = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != seen_ticket) begin
            seen_ticket = hold_ticket;
            stall_left = HOLD_CYCLES;
            run_left = 0;
         end
         if (stall_left == 0 && run_left > 0) begin
            run_left--;
         end else if (stall_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 4)
               run_left = $urandom_range(20, 60);
            else if (r >= 70)
               stall_left = idle_len();
         end
         rsp_bus.ready <= (stall_left == 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   // Check each result beat against the oldest queued match
   always @(posedge clock) begin
      match_rec_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_matches.size() == 0) begin
            $display("%0t: unexpected match start %0d edits %0d last %0b", $time,
                     $signed(rsp_bus.match_start), rsp_bus.edit_count,
                     rsp_bus.last_match);
            fail_count++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_bus.match_start !== want.start || rsp_bus.edit_count !== want.edits ||
                rsp_bus.last_match !== want.last) begin
               $display("%0t: mismatch, expected start %0d edits %0d last %0b, got %0d %0d %0b",
                        $time, $signed(want.start), want.edits, want.last,
                        $signed(rsp_bus.match_start), rsp_bus.edit_count,
                        rsp_bus.last_match);
               fail_count++;
            end
         end
      end
   end

   // Abort when no beat moves on any channel for too long
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WATCHDOG_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, quiet);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      int k;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.text_byte = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;
      fail_count   = 0;
      bytes_sent   = 0;
      tx_calm_left = 0;
      hold_ticket  = 0;
      for (k = 0; k < PAT_REGS; k++)
         pat_word[k] = '0;
      pat_len_reg = 6'd1;
      max_err_reg = 3'd0;
      for (k = 0; k < LEVELS; k++)
         level_vec[k] = '1;
      text_pos = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_negative_start();
      test_length_edges();
      test_text_extremes();
      test_backpressure();
      test_random_search();
      settle();

      if (fail_count == 0 && pending_matches.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule : tb

`default_nettype wire
